### rtl/bsts_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the quarter-wave sine table for the saw table block.
package bsts_pkg;

  localparam int INDEX_W    = 12;
  localparam int SAMPLE_W   = 16;
  localparam int LOG2_W     = 4;
  localparam int HARM_W     = 12;
  localparam int LOG2_EXT_W = 5;
  localparam int ACC_W      = 40;
  localparam int PHASE_W    = 12;
  localparam int QADDR_W    = 11;
  localparam int PROD_W     = 33;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_LENGTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HARMONICS = 1'b1;

  localparam logic [LOG2_W-1:0] LOG2_LENGTH_RST   = 4'd12;
  localparam logic [HARM_W-1:0] MAX_HARMONICS_RST = 12'd64;
  localparam logic [LOG2_EXT_W-1:0] MIN_LOG2      = 5'd2;

  localparam int QUARTER_PTS = 1024;
  localparam logic [QADDR_W-1:0] QUARTER_ADDR = 11'd1024;
  localparam logic [14:0] FULL_SCALE      = 15'd32767;
  localparam logic [15:0] TWO_OVER_PI_Q16 = 16'd41722;
  localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;

  // Taylor divisors (2n)(2n+1) for n = 1..10
  localparam int unsigned TAYLOR_DIV [1:10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

  typedef logic [14:0] qsine_tab_t [QUARTER_PTS+1];

  // Quarter-wave Q1.15 sine from a Q30 integer Taylor series, evaluated at elaboration.
  function automatic qsine_tab_t build_qsine();
    qsine_tab_t  tab;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    for (int j = 0; j <= QUARTER_PTS; j++) begin
      x    = (64'(j) * 64'(HALF_PI_Q30)) >> 10;
      term = x;
      sum  = x;
      for (int n = 1; n <= 10; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'(TAYLOR_DIV[n]);
        if (n[0]) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
      tab[j] = (v > 64'(FULL_SCALE)) ? FULL_SCALE : v[14:0];
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ABS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_SCALE
  } bsts_state_e;

  typedef struct packed {
    logic start;
    logic issue;
    logic fin_abs;
    logic fin_mul_lo;
    logic fin_mul_hi;
    logic fin_sum;
    logic fin_load;
  } bsts_cmd_t;

  typedef struct packed {
    logic last_issue;
    logic pipe_empty;
    logic out_free;
  } bsts_sts_t;

endpackage

### rtl/bsts_stream_ifs.sv
`timescale 1ns / 1ps
// Stream interfaces for index requests and table samples.
interface bsts_in_if;
  import bsts_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index;
  modport source (output valid, output index, input ready);
  modport sink   (input valid, input index, output ready);
endinterface

interface bsts_out_if;
  import bsts_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [INDEX_W-1:0]         entry_index;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output entry_index, output sample, input ready);
  modport sink   (input valid, input entry_index, input sample, output ready);
endinterface

### rtl/bsts_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for harmonic issue, pipeline drain and output scaling.
module bsts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bsts_pkg::bsts_sts_t sts_i,
  output bsts_pkg::bsts_cmd_t cmd_o
);
  import bsts_pkg::*;

  bsts_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.last_issue) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty) state_d = ST_ABS;
      end
      ST_ABS:    state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_SUM;
      ST_SUM:    state_d = ST_SCALE;
      ST_SCALE: begin
        // hold until the output register can take the beat
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.start  = in_valid_i;
      end
      ST_RUN:    cmd_o.issue      = 1'b1;
      ST_DRAIN:  cmd_o            = '0;
      ST_ABS:    cmd_o.fin_abs    = 1'b1;
      ST_MUL_LO: cmd_o.fin_mul_lo = 1'b1;
      ST_MUL_HI: cmd_o.fin_mul_hi = 1'b1;
      ST_SUM:    cmd_o.fin_sum    = 1'b1;
      ST_SCALE:  cmd_o.fin_load   = sts_i.out_free;
      default:   cmd_o            = '0;
    endcase
  end

endmodule

### rtl/bsts_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, phase and harmonic counters, sine/reciprocal ROMs, MAC, scaling.
module bsts_dp #(
  parameter int MAX_LENGTH_LOG2    = 12,
  parameter int MAX_HARMONIC_LIMIT = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bsts_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bsts_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [bsts_pkg::INDEX_W-1:0]        in_index_i,
  input  bsts_pkg::bsts_cmd_t                 cmd_i,
  output bsts_pkg::bsts_sts_t                 sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [bsts_pkg::INDEX_W-1:0]        out_index_o,
  output logic signed [bsts_pkg::SAMPLE_W-1:0] out_sample_o
);
  import bsts_pkg::*;

  localparam int PH_W        = (MAX_LENGTH_LOG2 > PHASE_W) ? MAX_LENGTH_LOG2 : PHASE_W;
  localparam int K_W         = $clog2(MAX_HARMONIC_LIMIT + 1);
  localparam int HC_W        = (K_W > HARM_W) ? K_W : HARM_W;
  localparam int RECIP_DEPTH = MAX_HARMONIC_LIMIT + 1;

  typedef logic [15:0] recip_tab_t [RECIP_DEPTH];

  // 1/k in Q0.16, rounded, saturated at the top code
  function automatic recip_tab_t build_recip();
    recip_tab_t  tab;
    logic [31:0] r;
    tab[0] = '0;
    for (int k = 1; k < RECIP_DEPTH; k++) begin
      r      = (32'd65536 + 32'(k >> 1)) / 32'(k);
      tab[k] = (r > 32'd65535) ? 16'hFFFF : r[15:0];
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP = build_recip();

  // configuration
  logic [LOG2_W-1:0] log2_length_q;
  logic [HARM_W-1:0] max_harm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_length_q <= LOG2_LENGTH_RST;
      max_harm_q    <= MAX_HARMONICS_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_LOG2_LENGTH) begin
        log2_length_q <= cfg_wdata_i[LOG2_W-1:0];
      end else if (cfg_idx_i == CFG_MAX_HARMONICS) begin
        max_harm_q    <= cfg_wdata_i[HARM_W-1:0];
      end
    end
  end

  // setup for a new index
  logic [LOG2_EXT_W-1:0] lg_ext, lg_c;
  logic [HC_W-1:0]       h_ext, h_c;
  logic [PH_W-1:0]       len_mask, step_d;
  logic [INDEX_W-1:0]    eff;
  logic                  is_last;

  always_comb begin
    lg_ext = LOG2_EXT_W'(log2_length_q);
    priority if (lg_ext < MIN_LOG2) begin
      lg_c = MIN_LOG2;
    end else if (lg_ext > LOG2_EXT_W'(MAX_LENGTH_LOG2)) begin
      lg_c = LOG2_EXT_W'(MAX_LENGTH_LOG2);
    end else begin
      lg_c = lg_ext;
    end

    h_ext = HC_W'(max_harm_q);
    priority if (h_ext == '0) begin
      h_c = HC_W'(1);
    end else if (h_ext > HC_W'(MAX_HARMONIC_LIMIT)) begin
      h_c = HC_W'(MAX_HARMONIC_LIMIT);
    end else begin
      h_c = h_ext;
    end

    len_mask = (PH_W'(1) << lg_c) - PH_W'(1);
    eff      = in_index_i & len_mask[INDEX_W-1:0];
    is_last  = (PH_W'(eff) == len_mask);
    // align the index so the top bits of the accumulator are the 12-bit phase
    step_d   = PH_W'(eff) << (LOG2_EXT_W'(PH_W) - lg_c);
  end

  logic [INDEX_W-1:0] index_q;
  logic               last_q;
  logic [PH_W-1:0]    step_q, phase_q;
  logic [K_W-1:0]     k_q, h_q;

  // sine address from the current phase
  logic [PHASE_W-1:0] ph;
  logic [QADDR_W-1:0] rom_addr;

  always_comb begin
    ph = phase_q[PH_W-1 -: PHASE_W];
    if (ph[10]) begin
      rom_addr = QUARTER_ADDR - {1'b0, ph[9:0]};
    end else begin
      rom_addr = {1'b0, ph[9:0]};
    end
  end

  // pipeline valids
  logic s1_vld_q, s2_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
    end
  end

  logic [14:0]              sin_rom_q;
  logic [15:0]              rcp_rom_q;
  logic                     sin_neg_q;
  logic signed [15:0]       sin_s;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  assign sin_s = sin_neg_q ? -$signed({1'b0, sin_rom_q}) : $signed({1'b0, sin_rom_q});

  // finishing arithmetic
  logic [ACC_W-1:0] mag_q;
  logic             neg_q;
  logic [35:0]      plo_q, phi_q;
  logic [ACC_W-1:0] v1_q;
  logic [54:0]      scaled;
  logic [23:0]      v2;
  logic [14:0]      sat;
  logic [15:0]      mag16;
  logic [15:0]      sample_d;
  logic [55:0]      sum56;

  always_comb begin
    sum56    = {phi_q[35:0], 20'b0} + {20'b0, plo_q};
    // v1 * 32767 as a shift and subtract
    scaled   = {v1_q, 15'b0} - {15'b0, v1_q};
    v2       = scaled[54:31];
    sat      = (v2 > 24'(FULL_SCALE)) ? FULL_SCALE : v2[14:0];
    mag16    = last_q ? 16'd0 : {1'b0, sat};
    sample_d = neg_q ? (16'd0 - mag16) : mag16;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      index_q <= in_index_i;
      last_q  <= is_last;
      step_q  <= step_d;
      phase_q <= step_d;
      k_q     <= K_W'(1);
      h_q     <= K_W'(h_c);
      acc_q   <= '0;
    end else begin
      if (cmd_i.issue) begin
        phase_q <= phase_q + step_q;
        k_q     <= k_q + K_W'(1);
      end
      if (s2_vld_q) begin
        acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
      end
    end

    // registered ROM reads
    sin_rom_q <= QSINE[rom_addr];
    rcp_rom_q <= RECIP[k_q];
    sin_neg_q <= ph[11];

    prod_q <= sin_s * $signed({1'b0, rcp_rom_q});

    if (cmd_i.fin_abs) begin
      neg_q <= acc_q[ACC_W-1];
      mag_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    end
    if (cmd_i.fin_mul_lo) plo_q <= mag_q[19:0] * TWO_OVER_PI_Q16;
    if (cmd_i.fin_mul_hi) phi_q <= mag_q[39:20] * TWO_OVER_PI_Q16;
    if (cmd_i.fin_sum)    v1_q  <= sum56[55:16];
  end

  // output register
  logic                       out_valid_q;
  logic [INDEX_W-1:0]         out_index_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_load) begin
      out_index_q  <= index_q;
      out_sample_q <= $signed(sample_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign out_sample_o = out_sample_q;

  assign sts_o.last_issue = (k_q == h_q);
  assign sts_o.pipe_empty = !s1_vld_q && !s2_vld_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

### rtl/bandlimited_saw_table_sample.sv
`timescale 1ns / 1ps
// Band-limited sawtooth wavetable entry: top level joining sequencer and datapath.
// An accepted index runs through harmonic issue, pipeline drain, magnitude, partial products,
// sum and scaling; harmonics pass one at a time through the single sine-ROM/MAC path.
// The output register lets the next index start while a sample waits to be taken.
// Reset (rst_ni low, asynchronous): sequencer idle, output empty, log2_length 12,
// max_harmonics 64; the sine and reciprocal ROMs need no initialization pass.
module bandlimited_saw_table_sample #(
  parameter int MAX_LENGTH_LOG2    = 12,
  parameter int MAX_HARMONIC_LIMIT = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bsts_in_if.sink                         in_if,
  bsts_out_if.source                      out_if,
  input  logic                            cfg_we_i,
  input  logic [bsts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bsts_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import bsts_pkg::*;

  bsts_cmd_t cmd;
  bsts_sts_t sts;
  logic      in_ready;

  bsts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsts_dp #(
    .MAX_LENGTH_LOG2    (MAX_LENGTH_LOG2),
    .MAX_HARMONIC_LIMIT (MAX_HARMONIC_LIMIT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_index_i   (in_if.index),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_if.ready),
    .out_valid_o  (out_if.valid),
    .out_index_o  (out_if.entry_index),
    .out_sample_o (out_if.sample)
  );

  assign in_if.ready = in_ready;

  // an accepted beat starts harmonic issue on the next cycle
  a_start_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> cmd.issue)
    else $error("harmonic issue did not follow an accepted index");

  // no new index is taken while harmonics are in flight
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !in_if.ready)
    else $error("input ready while harmonics are issued");

  // scaling must start only after the MAC pipeline has drained
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin_abs |-> sts.pipe_empty)
    else $error("magnitude taken before accumulator settled");

  // saturation keeps the sample inside symmetric full scale
  a_no_min_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.sample != 16'sh8000)
    else $error("sample reached the negative limit code");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the band-limited saw table block, with its own sample predictor.
module tb_top;

  localparam int CYCLE_LIMIT = 500000;
  localparam longint unsigned Q30_HALF_PI    = 64'd1686629713;
  localparam longint unsigned SCALE_2_PI_Q16 = 64'd41722;
  localparam longint unsigned SAT_LEVEL      = 64'd32767;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [11:0]        entry_index;
    logic signed [15:0] sample;
  } saw_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [bsts_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [bsts_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bsts_in_if  idx_bus ();
  bsts_out_if smp_bus ();

  bandlimited_saw_table_sample u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (idx_bus.sink),
    .out_if      (smp_bus.source),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  int quarter_sine [0:1024];
  logic [3:0]  log2_len_cfg  = 4'd12;
  logic [11:0] harmonics_cfg = 12'd64;
  saw_beat_t   pending_samples [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          no_idle = 1'b0;
  int          sink_hold_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Q1.15 quarter wave from a Q30 Taylor series, rounded half up
  function automatic void fill_quarter_sine();
    longint unsigned x, term, acc_s, v;
    for (int j = 0; j <= 1024; j++) begin
      x     = (u64_t'(j) * Q30_HALF_PI) / 64'd1024;
      term  = x;
      acc_s = x;
      for (int n = 1; n <= 10; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / u64_t'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc_s = (acc_s >= term) ? acc_s - term : 64'd0;
        else acc_s = acc_s + term;
      end
      v = (acc_s * SAT_LEVEL + (64'd1 << 29)) >> 30;
      quarter_sine[j] = (v > SAT_LEVEL) ? int'(SAT_LEVEL) : int'(v);
    end
  endfunction

  function automatic int unsigned clamp_log2(input logic [3:0] lg_reg);
    int unsigned lg;
    lg = lg_reg;
    if (lg < 2) lg = 2;
    if (lg > 12) lg = 12;
    return lg;
  endfunction

  function automatic saw_beat_t predict_entry(input logic [11:0] idx, input logic [3:0] lg_reg,
                                              input logic [11:0] h_reg);
    saw_beat_t beat;
    int unsigned lg, h, n_len, eff, ph, quad, r;
    int sine_v;
    longint acc;
    longint unsigned mag, v, recip;
    lg = clamp_log2(lg_reg);
    h = h_reg;
    if (h < 1) h = 1;
    if (h > 2048) h = 2048;
    n_len = 1 << lg;
    eff = idx & (n_len - 1);
    acc = 0;
    for (int unsigned k = 1; k <= h; k++) begin
      // low 12 bits survive any wrap of the 32-bit product
      ph = ((eff * k) << (12 - lg)) & 32'hFFF;
      quad = ph >> 10;
      r = ph & 32'h3FF;
      sine_v = quad[0] ? quarter_sine[1024 - r] : quarter_sine[r];
      if (quad[1]) sine_v = -sine_v;
      recip = (64'd65536 + k / 2) / k;
      if (recip > 64'd65535) recip = 64'd65535;
      acc += longint'(sine_v) * longint'(recip);
    end
    mag = (acc < 0) ? u64_t'(-acc) : u64_t'(acc);
    v = (mag * SCALE_2_PI_Q16) >> 16;
    v = (v * SAT_LEVEL) >> 31;
    if (v > SAT_LEVEL) v = SAT_LEVEL;
    if (eff == n_len - 1) v = 0;
    beat.entry_index = idx;
    beat.sample = 16'(v);
    if (acc < 0) beat.sample = -beat.sample;
    return beat;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Leave valid high on return so a back-to-back beat needs no second assignment.
  task automatic send_index(input logic [11:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      idx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    idx_bus.valid <= 1'b1;
    idx_bus.index <= idx;
    do @(posedge clk_i); while (!idx_bus.ready);
    pending_samples.push_back(predict_entry(idx, log2_len_cfg, harmonics_cfg));
  endtask

  task automatic wait_for_samples();
    idx_bus.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [11:0] lg_word, input logic [11:0] h_word);
    cfg_we    <= 1'b1;
    cfg_idx   <= bsts_pkg::CFG_LOG2_LENGTH;
    cfg_wdata <= lg_word;
    @(posedge clk_i);
    cfg_idx   <= bsts_pkg::CFG_MAX_HARMONICS;
    cfg_wdata <= h_word;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    log2_len_cfg  = lg_word[3:0];
    harmonics_cfg = h_word;
  endtask

  initial begin : sink_pacing
    int stall;
    smp_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
        smp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
        smp_bus.ready <= 1'b0;
        repeat (stall + 1) @(posedge clk_i);
      end else begin
        smp_bus.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    saw_beat_t exp_beat;
    if (rst_ni && smp_bus.valid && smp_bus.ready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected beat: entry_index %0d sample %0d",
               smp_bus.entry_index, smp_bus.sample);
        fail_count++;
      end else begin
        exp_beat = pending_samples.pop_front();
        if (smp_bus.entry_index !== exp_beat.entry_index) begin
          $error("entry_index: expected %0d, got %0d", exp_beat.entry_index,
                 smp_bus.entry_index);
          fail_count++;
        end
        if (smp_bus.sample !== exp_beat.sample) begin
          $error("sample: expected %0d, got %0d (entry_index %0d)", exp_beat.sample,
                 smp_bus.sample, exp_beat.entry_index);
          fail_count++;
        end
      end
    end
  end

  // Registers untouched since reset: 4096 entries, 64 harmonics.
  task automatic test_reset_defaults();
    send_index(12'd0);
    send_index(12'd1);
    send_index(12'd4095);
    send_index(12'd2048);
    send_index(12'd4094);
    send_index(12'hAAA);
    send_index(12'h555);
    wait_for_samples();
  endtask

  // Four-entry table, single harmonic; index wraps and length exponent clamps up.
  task automatic test_short_tables();
    set_config(12'd2, 12'd1);
    send_index(12'd0);
    send_index(12'd1);
    send_index(12'd3);
    send_index(12'd4095);
    wait_for_samples();
    set_config(12'd0, 12'd0);
    send_index(12'd2);
    send_index(12'd3);
    wait_for_samples();
  endtask

  // Both registers above their ranges, then harmonics at the top of theirs, length still above.
  task automatic test_clamped_extremes();
    set_config(12'hFFF, 12'd4095);
    send_index(12'd4094);
    send_index(12'd2049);
    wait_for_samples();
    set_config(12'd13, 12'd2048);
    send_index(12'd1);
    send_index(12'd4095);
    wait_for_samples();
  endtask

  // Positions next to the jump, where the partial sum overshoots full scale.
  task automatic test_gibbs_overshoot();
    set_config(12'd4, 12'd8);
    send_index(12'd1);
    wait_for_samples();
    set_config(12'd5, 12'd8);
    send_index(12'd2);
    send_index(12'd30);
    send_index(12'd31);
    wait_for_samples();
  endtask

  // Hold the output off long enough that the input stalls with beats still offered.
  task automatic test_output_backpressure();
    set_config(12'd6, 12'd1);
    no_idle = 1'b1;
    sink_hold_cycles = 400;
    for (int i = 0; i < 16; i++) send_index(12'($urandom_range(0, 4095)));
    wait_for_samples();
    no_idle = 1'b0;
  endtask

  task automatic test_random_sweep();
    logic [3:0]  lg;
    logic [11:0] h;
    logic [11:0] idx;
    int unsigned n_len;
    int n_items;
    int r;
    for (int p = 0; p < 10; p++) begin
      lg = 4'($urandom_range(0, 15));
      n_items = 28;
      r = $urandom_range(0, 9);
      if (p == 3) begin
        h = 12'($urandom_range(1024, 4095));
        n_items = 5;
      end else if (r < 2) h = 12'($urandom_range(0, 4));
      else if (r < 8) h = 12'($urandom_range(5, 64));
      else h = 12'($urandom_range(65, 200));
      set_config({8'($urandom_range(0, 255)), lg}, h);
      no_idle = (p == 5);
      n_len = 1 << clamp_log2(lg);
      for (int i = 0; i < n_items; i++) begin
        r = $urandom_range(0, 7);
        idx = 12'($urandom_range(0, 4095));
        // bias toward the last position (with random wrap bits) and the first few
        if (r == 0) idx = idx | 12'(n_len - 1);
        else if (r == 1) idx = 12'($urandom_range(0, 3));
        send_index(idx);
      end
      wait_for_samples();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    idx_bus.valid <= 1'b0;
    idx_bus.index <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= bsts_pkg::CFG_LOG2_LENGTH;
    cfg_wdata     <= '0;
    fill_quarter_sine();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_short_tables();
    test_clamped_extremes();
    test_gibbs_overshoot();
    test_output_backpressure();
    test_random_sweep();
    wait_for_samples();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### bandlimited_saw_table_sample.f
rtl/bsts_pkg.sv
rtl/bsts_stream_ifs.sv
rtl/bsts_ctrl.sv
rtl/bsts_dp.sv
rtl/bandlimited_saw_table_sample.sv
test/tb_top.sv
